// ===== sv/rtt_trimmed_mean_clock_sync_macros.svh =====
// assertion macros for the trimmed mean round trip clock sync block
// used by the top level; expects a clock and a reset signal in scope
`ifndef RTT_TRIMMED_MEAN_CLOCK_SYNC_MACROS_SVH
`define RTT_TRIMMED_MEAN_CLOCK_SYNC_MACROS_SVH
`ifndef SYNTHESIS
// same cycle implication, disabled during reset
`define RTTM_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next cycle implication, disabled during reset
`define RTTM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RTTM_ASSERT_IMP(name, ante, cons, msg)
`define RTTM_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== sv/rttm_pkg.sv =====
// shared types and constants for the trimmed mean clock sync block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rttm_pkg;

   // width of every millisecond time value
   localparam int TIME_W = 32;

   // reciprocal bits multiplied per divider cycle
   localparam int MUL_CHUNK_W = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MERGE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/rttm_ram.sv =====
// generic single write, single read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rttm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/rttm_div.sv =====
// divider by a fixed divisor through a multiply by its rounded-up reciprocal,
// one reciprocal chunk per cycle; depends on rttm_pkg
`timescale 1ns / 1ps
`default_nettype none

module rttm_div #(
   parameter int DIVIDEND_W = 35,
   parameter int DIVISOR    = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIVIDEND_W-1:0]         dividend,
   output logic                          done,
   output logic [rttm_pkg::TIME_W-1:0]   quotient
);

   localparam int CK    = rttm_pkg::MUL_CHUNK_W;
   localparam int LOGD  = $clog2(DIVISOR);
   // exact floor for every dividend below 2**DIVIDEND_W
   localparam int SHIFT = DIVIDEND_W + LOGD;
   localparam int MW    = DIVIDEND_W + 1;
   localparam int NCH   = (MW + CK - 1) / CK;
   localparam int RPW   = NCH * CK;
   localparam int PPW   = DIVIDEND_W + CK;
   localparam int CNTW  = $clog2(NCH + 1);
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RPW-1:0]  RECIP_C = RPW'(RECIP);
   localparam logic [CNTW-1:0] NCH_C   = CNTW'(NCH);
   localparam logic [CNTW-1:0] ONE_C   = CNTW'(1);

   logic [DIVIDEND_W-1:0]     dvd_ff;
   logic [RPW-1:0]            rcp_ff;
   logic [DIVIDEND_W-1:0]     acc_ff, acc_in;
   logic [RPW-1:0]            lo_ff, lo_in;
   logic [CNTW-1:0]           cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [PPW-1:0]            part, step;
   logic [RPW+CK-1:0]         lo_cat;
   logic [DIVIDEND_W+RPW-1:0] prod;

   // low chunk first: keep the high part, shift the settled bits out below
   assign part   = PPW'(dvd_ff) * PPW'(rcp_ff[CK-1:0]);
   assign step   = PPW'(acc_ff) + part;
   assign acc_in = step[PPW-1:CK];
   assign lo_cat = {step[CK-1:0], lo_ff};
   assign lo_in  = lo_cat[RPW+CK-1:CK];
   assign prod   = {acc_ff, lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == ONE_C);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == ONE_C)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rcp_ff <= RECIP_C;
         acc_ff <= '0;
         lo_ff  <= '0;
         cnt_ff <= NCH_C;
      end else if (busy_ff) begin
         rcp_ff <= rcp_ff >> CK;
         acc_ff <= acc_in;
         lo_ff  <= lo_in;
         cnt_ff <= cnt_ff - ONE_C;
      end
   end

   assign done     = done_ff;
   assign quotient = prod[SHIFT +: rttm_pkg::TIME_W];

endmodule

`default_nettype wire

// ===== sv/rtt_trimmed_mean_clock_sync.sv =====
// top level of the trimmed mean round trip time clock offset estimator
// depends on rttm_pkg, rttm_ram, rttm_div and the assertion macro header
//
// usage
//  - req channel: one time response item per handshake (local receive time,
//    echoed request time, server time, all in ms); taken when req_valid is
//    high and req_stall is low; req_stall stays high while an item is in work
//  - rsp channel: one result item per request item (round trip, mean round
//    trip, server clock delta, window full flag), held in an output register
//    until rsp_valid meets a low rsp_stall
//  - the round trips live in a ring memory; a second memory holds a sorted
//    copy in two banks, rebuilt each item by one merge pass that drops the
//    oldest value once the window is full and inserts the new one while summing the kept span
//  - steps per item: take it, load the value leaving the ring, one merge
//    pass over the sorted entries, the reciprocal multiply once the window
//    is full, then filling the output register; the merge pass over the
//    sorted memory takes most of an item's time
//  - a finished result may wait on rsp_stall while the next item is taken;
//    that item waits at the end of its work until the output register frees
//  - reset (synchronous) empties the window and the output register; memory
//    contents are not cleared, stale entries are never read
`timescale 1ns / 1ps
`default_nettype none
`include "rtt_trimmed_mean_clock_sync_macros.svh"

module rtt_trimmed_mean_clock_sync #(
   parameter int WINDOW            = 8,
   parameter int OUTLIERS_PER_SIDE = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rttm_pkg::TIME_W-1:0]       req_local_time_ms,
   input  logic [rttm_pkg::TIME_W-1:0]       req_request_time_ms,
   input  logic [rttm_pkg::TIME_W-1:0]       req_server_time_ms,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rttm_pkg::TIME_W-1:0]       rsp_rtt_ms,
   output logic [rttm_pkg::TIME_W-1:0]       rsp_mean_rtt_ms,
   output logic [rttm_pkg::TIME_W-1:0]       rsp_server_delta_ms,
   output logic                              rsp_window_full
);

   localparam int TW      = rttm_pkg::TIME_W;
   localparam int IW      = $clog2(WINDOW);           // ring / sorted index
   localparam int CW      = $clog2(WINDOW + 1);       // counts up to WINDOW
   localparam int SW      = IW + TW;                  // full precision sum
   localparam int TRIM_LO = OUTLIERS_PER_SIDE;
   localparam int TRIM_HI = WINDOW - OUTLIERS_PER_SIDE;
   // nothing kept leaves an empty sum, so any divisor gives zero
   localparam int DIVISOR = (2 * OUTLIERS_PER_SIDE >= WINDOW) ?
                            1 : (WINDOW - 2 * OUTLIERS_PER_SIDE);
   localparam int SRT_DEPTH = 2 ** (IW + 1);
   localparam logic [CW-1:0] W_C        = CW'(WINDOW);
   localparam logic [CW-1:0] W_M1_C     = CW'(WINDOW - 1);
   localparam logic [IW-1:0] LAST_IDX_C = IW'(WINDOW - 1);

   // control state
   rttm_pkg::state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;      // valid round trips in the window
   logic [IW-1:0] oldest_ff, oldest_in;  // ring slot the next round trip takes
   logic          bank_ff, bank_in;      // sorted bank holding the live list
   logic          rsp_valid_ff, rsp_valid_in;

   // per item working registers
   logic [TW-1:0] rtt_ff;                // local minus request
   logic [TW-1:0] srv_ff;                // server minus request
   logic [TW-1:0] old_ff;                // value leaving the window
   logic [CW-1:0] j_ff, j_in;            // read position in the live list
   logic [IW-1:0] p_ff;                  // write position in the new list
   logic [SW-1:0] sum_ff, sum_in;
   logic          ins_pend_ff;           // new round trip not yet placed
   logic          del_pend_ff;           // oldest value not yet dropped
   logic [TW-1:0] mean_ff;
   logic          full_ff;

   // output register
   logic [TW-1:0] rsp_rtt_ff, rsp_mean_ff, rsp_delta_ff;
   logic          rsp_full_ff;

   // memory ports
   logic [TW-1:0] ring_rd;
   logic          ring_we;
   logic [TW-1:0] srt_rd;
   logic          srt_we;
   logic [IW:0]   srt_rd_addr;
   logic [IW:0]   srt_wr_addr;
   logic [TW-1:0] srt_wr_data;

   // merge datapath
   logic full_old, new_full, src_avail, skip, take_ins, take_src, last_out;
   logic in_trim, merge_done, req_acc, emit_load;
   logic          div_start, div_done;
   logic [TW-1:0] div_q;

   assign req_acc   = req_valid && !req_stall;
   assign emit_load = (state_ff == rttm_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // window status before this item lands and after it
   assign full_old = (fill_ff == W_C);
   assign new_full = full_old || (fill_ff == W_M1_C);

   // one merge step: drop the oldest once, else emit the smaller head
   assign src_avail = (j_ff < fill_ff);
   assign skip      = src_avail && del_pend_ff && (srt_rd == old_ff);
   assign take_ins  = !skip && ins_pend_ff && (!src_avail || (rtt_ff <= srt_rd));
   assign take_src  = !skip && !take_ins;
   assign srt_wr_data = take_ins ? rtt_ff : srt_rd;
   assign last_out  = full_old ? (p_ff == LAST_IDX_C) : (p_ff == fill_ff[IW-1:0]);
   assign in_trim   = (int'(p_ff) >= TRIM_LO) && (int'(p_ff) < TRIM_HI);
   assign merge_done = srt_we && last_out;

   assign j_in   = j_ff + CW'(skip || take_src);
   assign sum_in = sum_ff + ((srt_we && in_trim) ? SW'(srt_wr_data) : SW'(0));

   assign srt_rd_addr = (state_ff == rttm_pkg::ST_MERGE) ?
                        {bank_ff, j_in[IW-1:0]} : {bank_ff, IW'(0)};
   assign srt_wr_addr = {~bank_ff, p_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rttm_pkg::ST_IDLE: begin
            if (req_valid) state_in = rttm_pkg::ST_LOAD;
         end
         rttm_pkg::ST_LOAD: begin
            state_in = rttm_pkg::ST_MERGE;
         end
         rttm_pkg::ST_MERGE: begin
            if (merge_done) state_in = new_full ? rttm_pkg::ST_DIVIDE : rttm_pkg::ST_EMIT;
         end
         rttm_pkg::ST_DIVIDE: begin
            if (div_done) state_in = rttm_pkg::ST_EMIT;
         end
         rttm_pkg::ST_EMIT: begin
            if (emit_load) state_in = rttm_pkg::ST_IDLE;
         end
         default: begin
            state_in = rttm_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      ring_we   = 1'b0;
      srt_we    = 1'b0;
      case (state_ff)
         rttm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         rttm_pkg::ST_LOAD: begin
            ring_we = 1'b1;
         end
         rttm_pkg::ST_MERGE: begin
            srt_we = !skip;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign div_start = merge_done && new_full;

   // window bookkeeping advances when the new sorted list is complete
   always_comb begin
      fill_in   = fill_ff;
      oldest_in = oldest_ff;
      bank_in   = bank_ff;
      if (merge_done) begin
         if (!full_old) fill_in = fill_ff + CW'(1);
         oldest_in = (oldest_ff == LAST_IDX_C) ? IW'(0) : oldest_ff + IW'(1);
         bank_in   = ~bank_ff;
      end
   end

   assign rsp_valid_in = emit_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rttm_pkg::ST_IDLE;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rtt_ff <= req_local_time_ms - req_request_time_ms;
         srv_ff <= req_server_time_ms - req_request_time_ms;
      end
      if (state_ff == rttm_pkg::ST_LOAD) begin
         old_ff      <= ring_rd;
         j_ff        <= '0;
         p_ff        <= '0;
         sum_ff      <= '0;
         ins_pend_ff <= 1'b1;
         del_pend_ff <= full_old;
      end
      if (state_ff == rttm_pkg::ST_MERGE) begin
         j_ff   <= j_in;
         sum_ff <= sum_in;
         if (srt_we) p_ff <= p_ff + IW'(1);
         if (take_ins) ins_pend_ff <= 1'b0;
         if (skip) del_pend_ff <= 1'b0;
      end
      if (merge_done) begin
         full_ff <= new_full;
         mean_ff <= rtt_ff;
      end
      if (div_done) begin
         mean_ff <= div_q;
      end
      if (emit_load) begin
         rsp_rtt_ff   <= rtt_ff;
         rsp_mean_ff  <= mean_ff;
         rsp_delta_ff <= srv_ff - {1'b0, mean_ff[TW-1:1]};
         rsp_full_ff  <= full_ff;
      end
   end

   // ring of round trips in arrival order
   rttm_ram #(
      .WIDTH (TW),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (oldest_ff),
      .wr_data (rtt_ff),
      .rd_addr (oldest_ff),
      .rd_data (ring_rd)
   );

   // sorted copy, two banks: read the live one, write the other
   rttm_ram #(
      .WIDTH (TW),
      .DEPTH (SRT_DEPTH)
   ) u_sorted (
      .clock   (clock),
      .wr_en   (srt_we),
      .wr_addr (srt_wr_addr),
      .wr_data (srt_wr_data),
      .rd_addr (srt_rd_addr),
      .rd_data (srt_rd)
   );

   rttm_div #(
      .DIVIDEND_W (SW),
      .DIVISOR    (DIVISOR)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rtt_ms          = rsp_rtt_ff;
   assign rsp_mean_rtt_ms     = rsp_mean_ff;
   assign rsp_server_delta_ms = rsp_delta_ff;
   assign rsp_window_full     = rsp_full_ff;

   // merge never runs past the end of both sources
   `RTTM_ASSERT_IMP(a_merge_source, state_ff == rttm_pkg::ST_MERGE, src_avail || ins_pend_ff, "merge ran dry")
   // fill count never passes the window size
   `RTTM_ASSERT_IMP(a_fill_bound, 1'b1, fill_ff <= W_C, "fill count beyond window")
   // a full window stays full
   `RTTM_ASSERT_NEXT(a_full_sticky, fill_ff == W_C, fill_ff == W_C, "window lost fill")
   // divider answers only while the block waits for it
   `RTTM_ASSERT_IMP(a_div_state, div_done, state_ff == rttm_pkg::ST_DIVIDE, "stray divider result")

endmodule

`default_nettype wire

// ===== verif/rtt_trimmed_mean_clock_sync_tb.sv =====
// self-checking bench for the trimmed mean round trip clock sync block
// depends on rttm_pkg and rtt_trimmed_mean_clock_sync; keeps its own window model
`timescale 1ns / 1ps

module rtt_trimmed_mean_clock_sync_tb;

   localparam int TIME_W = rttm_pkg::TIME_W;

   // block sizing, handed to the instance and mirrored by the window model
   localparam int WINDOW_SIZE   = 8;
   localparam int TRIM_PER_SIDE = 1;

   // random part length, idle watchdog and quiet time after the last result
   localparam int RANDOM_ITEMS = 1950;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 60;

   // receiver stall behaviors, switched at random phase lengths
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SCATTER,
      STALL_RUNS,
      STALL_HEAVY
   } stall_mode_type;

   // one result item as the block presents it
   typedef struct packed {
      logic [TIME_W-1:0] rtt_ms;
      logic [TIME_W-1:0] mean_rtt_ms;
      logic [TIME_W-1:0] server_delta_ms;
      logic              window_full;
   } offset_result_type;

   // clock and reset, reset starts high and is released at a falling edge
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side, all low or zero until the first item
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [TIME_W-1:0] req_local_time_ms   = '0;
   logic [TIME_W-1:0] req_request_time_ms = '0;
   logic [TIME_W-1:0] req_server_time_ms  = '0;

   // result side
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [TIME_W-1:0] rsp_rtt_ms;
   logic [TIME_W-1:0] rsp_mean_rtt_ms;
   logic [TIME_W-1:0] rsp_server_delta_ms;
   logic              rsp_window_full;

   // receiver pattern state
   stall_mode_type stall_mode       = STALL_NONE;
   int unsigned    stall_phase_left = 0;

   // cycles since the last handshake on either channel
   int unsigned idle_count = 0;

   // ---------------------------------------------------------------------
   // window model: ring of round trips, trimmed mean, clock delta, and the
   // queue of results still owed by the block
   // ---------------------------------------------------------------------
   class clock_offset_ledger;
      logic [TIME_W-1:0] rtt_ring[WINDOW_SIZE];
      int unsigned       ring_fill;
      int unsigned       ring_next;
      offset_result_type offsets_due[$];
      int unsigned       mismatches;

      function new();
         ring_fill  = 0;
         ring_next  = 0;
         mismatches = 0;
         foreach (rtt_ring[k]) rtt_ring[k] = '0;
      endfunction

      // one accepted time response: update the ring and queue its result
      function void note_item(logic [TIME_W-1:0] local_ms, logic [TIME_W-1:0] request_ms,
                              logic [TIME_W-1:0] server_ms);
         logic [TIME_W-1:0] ordered[WINDOW_SIZE];
         logic [TIME_W-1:0] held;
         logic [63:0]       kept_sum;
         offset_result_type owed;
         int                j;

         // round trip wraps like the clocks do
         owed.rtt_ms = local_ms - request_ms;
         rtt_ring[ring_next] = owed.rtt_ms;
         ring_next = (ring_next + 1) % WINDOW_SIZE;
         if (ring_fill < WINDOW_SIZE) ring_fill++;
         owed.window_full = (ring_fill == WINDOW_SIZE);

         if (!owed.window_full) begin
            owed.mean_rtt_ms = owed.rtt_ms;
         end else if (2 * TRIM_PER_SIDE >= WINDOW_SIZE) begin
            // trimming leaves nothing to average
            owed.mean_rtt_ms = '0;
         end else begin
            // insertion sort of a copy, then a wide sum of the kept span
            ordered = rtt_ring;
            for (int i = 1; i < WINDOW_SIZE; i++) begin
               held = ordered[i];
               j = i;
               while (j > 0 && ordered[j-1] > held) begin
                  ordered[j] = ordered[j-1];
                  j--;
               end
               ordered[j] = held;
            end
            kept_sum = '0;
            for (int i = TRIM_PER_SIDE; i < WINDOW_SIZE - TRIM_PER_SIDE; i++)
               kept_sum += 64'(ordered[i]);
            owed.mean_rtt_ms = TIME_W'(kept_sum / 64'(WINDOW_SIZE - 2 * TRIM_PER_SIDE));
         end

         owed.server_delta_ms = server_ms - request_ms - (owed.mean_rtt_ms >> 1);
         offsets_due.insert(offsets_due.size(), owed);
      endfunction

      function void compare_field(string field, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // one accepted result, checked against the oldest owed result
      function void check_result(offset_result_type got);
         offset_result_type want;
         if (offsets_due.size() == 0) begin
            $display("%0t: result with nothing owed, expected none actual rtt %h",
                     $time, got.rtt_ms);
            mismatches++;
         end else begin
            want = offsets_due[0];
            offsets_due.delete(0);
            compare_field("rtt_ms", want.rtt_ms, got.rtt_ms);
            compare_field("mean_rtt_ms", want.mean_rtt_ms, got.mean_rtt_ms);
            compare_field("server_delta_ms", want.server_delta_ms, got.server_delta_ms);
            compare_field("window_full", TIME_W'(want.window_full), TIME_W'(got.window_full));
         end
      endfunction
   endclass

   clock_offset_ledger ledger = new();

   // ---------------------------------------------------------------------
   // block under test
   // ---------------------------------------------------------------------
   rtt_trimmed_mean_clock_sync #(
      .WINDOW           (WINDOW_SIZE),
      .OUTLIERS_PER_SIDE(TRIM_PER_SIDE)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_local_time_ms  (req_local_time_ms),
      .req_request_time_ms(req_request_time_ms),
      .req_server_time_ms (req_server_time_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rtt_ms         (rsp_rtt_ms),
      .rsp_mean_rtt_ms    (rsp_mean_rtt_ms),
      .rsp_server_delta_ms(rsp_server_delta_ms),
      .rsp_window_full    (rsp_window_full)
   );

   always #5 clock = ~clock;

   // receiver stall: a mode is held for a random phase, then redrawn
   always @(negedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       <= stall_mode_type'($urandom_range(0, 3));
         stall_phase_left <= $urandom_range(20, 250);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_mode)
         STALL_NONE:    rsp_stall <= 1'b0;
         STALL_SCATTER: rsp_stall <= 1'($urandom_range(0, 1));
         // toggles rarely, so stalls and free stretches come in runs
         STALL_RUNS:    rsp_stall <= ($urandom_range(0, 7) == 0) ? ~rsp_stall : rsp_stall;
         STALL_HEAVY:   rsp_stall <= ($urandom_range(0, 3) != 0);
         default:       rsp_stall <= 1'b0;
      endcase
   end

   // handshake sampling at the rising edge, plus the idle watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            ledger.note_item(req_local_time_ms, req_request_time_ms, req_server_time_ms);
         if (rsp_valid && !rsp_stall)
            ledger.check_result({rsp_rtt_ms, rsp_mean_rtt_ms, rsp_server_delta_ms,
                                 rsp_window_full});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_count <= 0;
         else
            idle_count <= idle_count + 1;
         if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // present one item at the falling edge and hold it until taken
   task automatic offer_item(input logic [TIME_W-1:0] local_ms,
                             input logic [TIME_W-1:0] request_ms,
                             input logic [TIME_W-1:0] server_ms);
      @(negedge clock);
      req_valid           <= 1'b1;
      req_local_time_ms   <= local_ms;
      req_request_time_ms <= request_ms;
      req_server_time_ms  <= server_ms;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid for the given number of rising edges
   task automatic hold_off(input int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   initial begin
      int unsigned       burst_left;
      int unsigned       pick;
      logic [TIME_W-1:0] request_ms;
      logic [TIME_W-1:0] server_ms;
      logic [TIME_W-1:0] trip_ms;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first window fill with field extremes and wrapping trips
      offer_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      offer_item(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);   // trip wraps to 1
      offer_item(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);   // largest trip
      offer_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_item(32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF);
      offer_item(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
      offer_item(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
      offer_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);   // window now full
      // largest trips fill the window so the kept sum needs more than 32 bits
      for (int i = 0; i < 8; i++)
         offer_item(32'h7FFF_FFFE, 32'h7FFF_FFFF, TIME_W'(i));
      // equal trips, then a zero trip and a near-largest trip with the delta wrapping below zero
      for (int i = 0; i < 4; i++)
         offer_item(32'd1100 + TIME_W'(i), 32'd1000 + TIME_W'(i), 32'd2000);
      offer_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0000);
      offer_item(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);

      // random: mostly small trips with spikes, some anywhere, some near wrap
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
         end
         pick       = $urandom_range(0, 19);
         request_ms = $urandom();
         server_ms  = $urandom();
         if (pick == 0)
            trip_ms = $urandom_range(0, 1000000);
         else if (pick < 14)
            trip_ms = $urandom_range(0, 400);
         else if (pick < 17)
            trip_ms = $urandom();
         else if (pick < 19)
            trip_ms = 32'hFFFF_FFFF - $urandom_range(0, 255);
         else
            trip_ms = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
         offer_item(request_ms + trip_ms, request_ms, server_ms);
         burst_left--;
      end
      hold_off(1);

      // wait for every owed result, then watch for strays
      while (ledger.offsets_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.mismatches == 0 && ledger.offsets_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rttm_pkg.sv
sv/rttm_ram.sv
sv/rttm_div.sv
sv/rtt_trimmed_mean_clock_sync.sv
verif/rtt_trimmed_mean_clock_sync_tb.sv
